// ----- rtl/core/cmf_pkg.sv -----
// package for the complex magnitude datapath: side-band struct, exponent type,
// special-value constants and the binary32 unpack helper
// no dependencies
`timescale 1ns / 1ps

package cmf_pkg;

  localparam logic [30:0] InfAbs   = 31'h7F800000;
  localparam logic [31:0] InfBits  = 32'h7F800000;
  localparam logic [31:0] QnanBits = 32'h7FC00000;
  localparam logic [31:0] ZeroBits = 32'h00000000;

  // quotient bits of the divider chain and root bits of the square-root chain
  localparam int DivSteps  = 56;
  localparam int SqrtSteps = 54;

  typedef logic signed [11:0] cmf_exp_t;

  // travels next to the arithmetic through every stage and cell before the output register
  typedef struct packed {
    logic        special;
    logic [31:0] special_bits;
    logic [23:0] big_man;
    cmf_exp_t    big_exp;
    cmf_exp_t    q_exp;
  } cmf_side_t;

  // value = man * 2^(exp - 23), man normalized to [2^23, 2^24)
  typedef struct packed {
    logic [23:0] man;
    cmf_exp_t    exp;
  } cmf_unpacked_t;

  function automatic cmf_unpacked_t cmf_unpack(input logic [30:0] a);
    cmf_unpacked_t u;
    logic [4:0]    lz;
    logic [23:0]   wide;
    lz = 5'd23;
    for (int i = 0; i < 23; i++) begin
      if (a[i]) lz = 5'(22 - i);
    end
    wide = {1'b0, a[22:0]} << (lz + 5'd1);
    if (a[30:23] != 8'd0) begin
      u.man = {1'b1, a[22:0]};
      u.exp = $signed({4'b0, a[30:23]}) - 12'sd127;
    end else begin
      // subnormal: normalize the fraction
      u.man = wide;
      u.exp = -12'sd127 - $signed({7'b0, lz});
    end
    return u;
  endfunction

endpackage

// ----- rtl/core/complex_magnitude_f32.sv -----
// stages: unpack register, 56-cell divider chain, 54-cell square-root chain with nine
// rounding/multiply stages before and after it, output register
// throughput: one transaction per cycle; the whole pipeline holds only when the
// output register and its skid stage are both full
// reset: synchronous active-low rst_n clears all valid bits; payload is not reset
`timescale 1ns / 1ps

module complex_magnitude_f32 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // real_bits[31:0], imag_bits[63:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // magnitude_bits[31:0]
);
  import cmf_pkg::*;

  logic en;

  // ---------------- unpack and classify
  logic [30:0]   ra, ib, big_abs, small_abs;
  cmf_unpacked_t ub, us;
  cmf_side_t     a_side_nxt;

  assign ra        = in_tdata[30:0];
  assign ib        = in_tdata[62:32];
  assign big_abs   = (ra > ib) ? ra : ib;
  assign small_abs = (ra > ib) ? ib : ra;
  assign ub        = cmf_unpack(big_abs);
  assign us        = cmf_unpack(small_abs);

  always_comb begin
    a_side_nxt.big_man = ub.man;
    a_side_nxt.big_exp = ub.exp;
    a_side_nxt.q_exp   = us.exp - ub.exp;
    priority if (ra == InfAbs || ib == InfAbs) begin
      a_side_nxt.special      = 1'b1;
      a_side_nxt.special_bits = InfBits;
    end else if (ra > InfAbs || ib > InfAbs) begin
      a_side_nxt.special      = 1'b1;
      a_side_nxt.special_bits = QnanBits;
    end else if (ra == 31'd0 && ib == 31'd0) begin
      a_side_nxt.special      = 1'b1;
      a_side_nxt.special_bits = ZeroBits;
    end else begin
      a_side_nxt.special      = 1'b0;
      a_side_nxt.special_bits = ZeroBits;
    end
  end

  // ---------------- divider chain: index 0 is the unpack register
  logic                div_v    [0:DivSteps];
  cmf_side_t           div_side [0:DivSteps];
  logic [24:0]         div_rem  [0:DivSteps];
  logic [DivSteps-1:0] div_quo  [0:DivSteps];

  logic        a_v_r;
  cmf_side_t   a_side_r;
  logic [23:0] a_small_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side_r  <= a_side_nxt;
      a_small_r <= us.man;
    end
  end

  assign div_v[0]    = a_v_r;
  assign div_side[0] = a_side_r;
  assign div_rem[0]  = {1'b0, a_small_r};
  assign div_quo[0]  = '0;

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    cmf_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .v_in     (div_v[j]),
      .side_in  (div_side[j]),
      .rem_in   (div_rem[j]),
      .quo_in   (div_quo[j]),
      .v_out    (div_v[j+1]),
      .side_out (div_side[j+1]),
      .rem_out  (div_rem[j+1]),
      .quo_out  (div_quo[j+1])
    );
  end

  // ---------------- round quotient to 53 bits
  logic [DivSteps-1:0] qq;
  logic                q_lead, q_g, q_s, q_rnd;
  logic [52:0]         q_pre;
  logic [53:0]         q_sum;
  logic                qr_v_r;
  cmf_side_t           qr_side_r;
  logic [52:0]         qr_man_r, qr_man_nxt;
  cmf_exp_t            qr_exp_r, qr_exp_nxt;

  assign qq         = div_quo[DivSteps];
  assign q_lead     = qq[55];
  assign q_pre      = q_lead ? qq[55:3] : qq[54:2];
  assign q_g        = q_lead ? qq[2] : qq[1];
  assign q_s        = (q_lead ? (|qq[1:0]) : qq[0]) | (div_rem[DivSteps] != 25'd0);
  assign q_rnd      = q_g & (q_s | q_pre[0]);
  assign q_sum      = {1'b0, q_pre} + 54'(q_rnd);
  assign qr_man_nxt = q_sum[53] ? q_sum[53:1] : q_sum[52:0];
  assign qr_exp_nxt = div_side[DivSteps].q_exp + $signed({11'b0, q_sum[53]})
                      - $signed({11'b0, !q_lead});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qr_v_r <= 1'b0;
    end else if (en) begin
      qr_v_r <= div_v[DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qr_side_r <= div_side[DivSteps];
      qr_man_r  <= qr_man_nxt;
      qr_exp_r  <= qr_exp_nxt;
    end
  end

  // ---------------- square: partial products
  logic        sq_v_r;
  cmf_side_t   sq_side_r;
  cmf_exp_t    sq_exp_r;
  logic [51:0] sq_hh_r;
  logic [52:0] sq_hl_r;
  logic [53:0] sq_ll_r;
  logic [25:0] q_hi;
  logic [26:0] q_lo;

  assign q_hi = qr_man_r[52:27];
  assign q_lo = qr_man_r[26:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
    end else if (en) begin
      sq_v_r <= qr_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side_r <= qr_side_r;
      sq_exp_r  <= qr_exp_r;
      sq_hh_r   <= {26'b0, q_hi} * {26'b0, q_hi};
      sq_hl_r   <= {27'b0, q_hi} * {26'b0, q_lo};
      sq_ll_r   <= {27'b0, q_lo} * {27'b0, q_lo};
    end
  end

  // ---------------- square: sum of partials
  logic         ss_v_r;
  cmf_side_t    ss_side_r;
  cmf_exp_t     ss_exp_r;
  logic [105:0] ss_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ss_v_r <= 1'b0;
    end else if (en) begin
      ss_v_r <= sq_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ss_side_r <= sq_side_r;
      ss_exp_r  <= sq_exp_r;
      ss_sq_r   <= (106'(sq_hh_r) << 54) + (106'(sq_hl_r) << 28) + 106'(sq_ll_r);
    end
  end

  // ---------------- square: round to 53 bits
  logic        p_lead, p_g, p_s, p_rnd;
  logic [52:0] p_pre;
  logic [53:0] p_sum;
  logic        sr_v_r;
  cmf_side_t   sr_side_r;
  logic [52:0] sr_man_r;
  cmf_exp_t    sr_exp_r;

  assign p_lead = ss_sq_r[105];
  assign p_pre  = p_lead ? ss_sq_r[105:53] : ss_sq_r[104:52];
  assign p_g    = p_lead ? ss_sq_r[52] : ss_sq_r[51];
  assign p_s    = p_lead ? (|ss_sq_r[51:0]) : (|ss_sq_r[50:0]);
  assign p_rnd  = p_g & (p_s | p_pre[0]);
  assign p_sum  = {1'b0, p_pre} + 54'(p_rnd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_v_r <= 1'b0;
    end else if (en) begin
      sr_v_r <= ss_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sr_side_r <= ss_side_r;
      sr_man_r  <= p_sum[53] ? p_sum[53:1] : p_sum[52:0];
      sr_exp_r  <= {ss_exp_r[10:0], 1'b0} + $signed({11'b0, p_lead})
                   + $signed({11'b0, p_sum[53]});
    end
  end

  // ---------------- 1 + q^2 rounded to 53 bits, result scaled by 2^52
  cmf_exp_t     neg_exp;
  logic         shift_all;
  logic [5:0]   shamt;
  logic [118:0] al_wide;
  logic [54:0]  al_ext;
  logic         al_stk;
  logic [55:0]  al_total;
  logic         al_rnd;
  logic [53:0]  ad_t_nxt;

  assign neg_exp   = (sr_exp_r > 12'sd0) ? 12'sd0 : -sr_exp_r;
  assign shift_all = neg_exp > 12'sd63;
  assign shamt     = shift_all ? 6'd0 : neg_exp[5:0];
  assign al_wide   = {sr_man_r, 2'b00, 64'b0} >> shamt;
  assign al_ext    = shift_all ? 55'd0 : al_wide[118:64];
  assign al_stk    = shift_all ? (|sr_man_r) : (|al_wide[63:0]);
  assign al_total  = (56'd1 << 54) + {1'b0, al_ext};
  assign al_rnd    = al_total[1] & (al_total[0] | al_stk | al_total[2]);
  assign ad_t_nxt  = al_total[55:2] + 54'(al_rnd);

  logic        ad_v_r;
  cmf_side_t   ad_side_r;
  logic [53:0] ad_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ad_v_r <= 1'b0;
    end else if (en) begin
      ad_v_r <= sr_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ad_side_r <= sr_side_r;
      ad_t_r    <= ad_t_nxt;
    end
  end

  // ---------------- square-root chain: index 0 is the add register
  logic        rt_v    [0:SqrtSteps];
  cmf_side_t   rt_side [0:SqrtSteps];
  logic [53:0] rt_m    [0:SqrtSteps];
  logic [57:0] rt_rem  [0:SqrtSteps];
  logic [53:0] rt_root [0:SqrtSteps];

  assign rt_v[0]    = ad_v_r;
  assign rt_side[0] = ad_side_r;
  assign rt_m[0]    = ad_t_r;
  assign rt_rem[0]  = '0;
  assign rt_root[0] = '0;

  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
    cmf_sqrt_cell #(
      .IDX (SqrtSteps - 1 - j)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .v_in     (rt_v[j]),
      .side_in  (rt_side[j]),
      .m_in     (rt_m[j]),
      .rem_in   (rt_rem[j]),
      .root_in  (rt_root[j]),
      .v_out    (rt_v[j+1]),
      .side_out (rt_side[j+1]),
      .m_out    (rt_m[j+1]),
      .rem_out  (rt_rem[j+1]),
      .root_out (rt_root[j+1])
    );
  end

  // ---------------- round root to 53 bits
  logic [52:0] r_res, r_sum;
  logic        r_up;
  logic        rr_v_r;
  cmf_side_t   rr_side_r;
  logic [52:0] rr_man_r;

  assign r_res = rt_root[SqrtSteps][53:1];
  assign r_up  = rt_root[SqrtSteps][0] & ((rt_rem[SqrtSteps] != 58'd0) | r_res[0]);
  assign r_sum = r_res + 53'(r_up);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rr_v_r <= 1'b0;
    end else if (en) begin
      rr_v_r <= rt_v[SqrtSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rr_side_r <= rt_side[SqrtSteps];
      rr_man_r  <= {1'b1, r_sum[51:0]};
    end
  end

  // ---------------- big * root: partial products
  logic        pp_v_r;
  cmf_side_t   pp_side_r;
  logic [49:0] pp_hi_r;
  logic [50:0] pp_lo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_v_r <= 1'b0;
    end else if (en) begin
      pp_v_r <= rr_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_side_r <= rr_side_r;
      pp_hi_r   <= {26'b0, rr_side_r.big_man} * {24'b0, rr_man_r[52:27]};
      pp_lo_r   <= {27'b0, rr_side_r.big_man} * {24'b0, rr_man_r[26:0]};
    end
  end

  // ---------------- big * root: sum
  logic        ps_v_r;
  cmf_side_t   ps_side_r;
  logic [76:0] ps_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_v_r <= 1'b0;
    end else if (en) begin
      ps_v_r <= pp_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ps_side_r <= pp_side_r;
      ps_prod_r <= (77'(pp_hi_r) << 27) + 77'(pp_lo_r);
    end
  end

  // ---------------- round product to 53 bits
  logic        d_lead, d_g, d_s, d_rnd;
  logic [52:0] d_pre;
  logic [53:0] d_sum;
  logic        dr_v_r;
  cmf_side_t   dr_side_r;
  logic [52:0] dr_man_r;
  cmf_exp_t    dr_exp_r;

  assign d_lead = ps_prod_r[76];
  assign d_pre  = d_lead ? ps_prod_r[76:24] : ps_prod_r[75:23];
  assign d_g    = d_lead ? ps_prod_r[23] : ps_prod_r[22];
  assign d_s    = d_lead ? (|ps_prod_r[22:0]) : (|ps_prod_r[21:0]);
  assign d_rnd  = d_g & (d_s | d_pre[0]);
  assign d_sum  = {1'b0, d_pre} + 54'(d_rnd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dr_v_r <= 1'b0;
    end else if (en) begin
      dr_v_r <= ps_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dr_side_r <= ps_side_r;
      dr_man_r  <= d_sum[53] ? d_sum[53:1] : d_sum[52:0];
      dr_exp_r  <= ps_side_r.big_exp + $signed({11'b0, d_lead})
                   + $signed({11'b0, d_sum[53]});
    end
  end

  // ---------------- narrow to binary32, nearest even, subnormal aware
  cmf_exp_t     f_ef, f_neg;
  logic         f_norm, f_inf;
  logic [4:0]   f_sh;
  logic [116:0] f_wide;
  logic [23:0]  f_keep;
  logic         f_g, f_s, f_rnd;
  logic [7:0]   f_expf;
  logic [31:0]  f_bits;
  logic [31:0]  res_bits;

  assign f_ef   = dr_exp_r + 12'sd127;
  assign f_neg  = 12'sd1 - f_ef;
  assign f_inf  = f_ef >= 12'sd255;
  assign f_norm = f_ef >= 12'sd1;
  assign f_sh   = f_norm ? 5'd0 : ((f_neg > 12'sd31) ? 5'd31 : f_neg[4:0]);
  assign f_wide = {dr_man_r, 64'b0} >> f_sh;
  assign f_keep = f_wide[116:93];
  assign f_g    = f_wide[92];
  assign f_s    = |f_wide[91:0];
  assign f_rnd  = f_g & (f_s | f_keep[0]);
  // the hidden bit of a normal value lands on the exponent field and adds one
  assign f_expf = f_norm ? 8'(f_ef - 12'sd1) : 8'd0;
  assign f_bits = f_inf ? InfBits
                        : ({1'b0, f_expf, 23'b0} + {8'b0, f_keep} + 32'(f_rnd));
  assign res_bits = dr_side_r.special ? dr_side_r.special_bits : f_bits;

  // ---------------- output register with skid stage
  logic        out_v_r, out_v_nxt;
  logic [31:0] out_d_r, out_d_nxt;
  logic        sk_v_r, sk_v_nxt;
  logic [31:0] sk_d_r, sk_d_nxt;
  logic        out_take;

  assign en       = !sk_v_r;
  assign out_take = out_v_r && out_tready;

  always_comb begin
    out_v_nxt = out_v_r;
    out_d_nxt = out_d_r;
    sk_v_nxt  = sk_v_r;
    sk_d_nxt  = sk_d_r;
    priority if (sk_v_r) begin
      if (out_take) begin
        out_v_nxt = 1'b1;
        out_d_nxt = sk_d_r;
        sk_v_nxt  = 1'b0;
      end
    end else if (!out_v_r || out_take) begin
      out_v_nxt = dr_v_r;
      out_d_nxt = res_bits;
    end else if (dr_v_r) begin
      sk_v_nxt = 1'b1;
      sk_d_nxt = res_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      sk_v_r  <= sk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r <= out_d_nxt;
    sk_d_r  <= sk_d_nxt;
  end

  assign in_tready  = en;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  // skid stage only ever sits behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_v_r |-> out_v_r)
    else $error("skid holds a result while the output register is empty");

  // a finished result meeting a stalled output must land in the skid stage
  a_skid_catches: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready && dr_v_r && !sk_v_r) |=> sk_v_r)
    else $error("result dropped at a stalled output");

  // a magnitude never carries the sign bit
  a_non_negative: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !out_d_r[31])
    else $error("negative magnitude on the output");

endmodule

// ----- rtl/core/cmf_div_cell.sv -----
// one restoring-division step of the ratio small/big, one quotient bit per cell
// depends on cmf_pkg
`timescale 1ns / 1ps

module cmf_div_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             v_in,
  input  cmf_pkg::cmf_side_t               side_in,
  input  logic [24:0]                      rem_in,
  input  logic [cmf_pkg::DivSteps-1:0]     quo_in,
  output logic                             v_out,
  output cmf_pkg::cmf_side_t               side_out,
  output logic [24:0]                      rem_out,
  output logic [cmf_pkg::DivSteps-1:0]     quo_out
);
  import cmf_pkg::*;

  logic                v_r;
  cmf_side_t           side_r;
  logic [24:0]         rem_r;
  logic [24:0]         rem_nxt;
  logic [DivSteps-1:0] quo_r;
  logic [DivSteps-1:0] quo_nxt;
  logic [24:0]         divisor;
  logic                ge;
  logic [24:0]         part;

  assign divisor = {1'b0, side_in.big_man};
  assign ge      = rem_in >= divisor;
  assign part    = ge ? (rem_in - divisor) : rem_in;
  // partial remainder stays below the divisor, so the shift cannot lose a bit
  assign rem_nxt = {part[23:0], 1'b0};
  assign quo_nxt = {quo_in[DivSteps-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_in;
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
    end
  end

  assign v_out    = v_r;
  assign side_out = side_r;
  assign rem_out  = rem_r;
  assign quo_out  = quo_r;

endmodule

// ----- rtl/core/cmf_sqrt_cell.sv -----
// one digit-by-digit square-root step, one root bit per cell
// depends on cmf_pkg
`timescale 1ns / 1ps

module cmf_sqrt_cell #(
  parameter int IDX = 53
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               v_in,
  input  cmf_pkg::cmf_side_t side_in,
  input  logic [53:0]        m_in,
  input  logic [57:0]        rem_in,
  input  logic [53:0]        root_in,
  output logic               v_out,
  output cmf_pkg::cmf_side_t side_out,
  output logic [53:0]        m_out,
  output logic [57:0]        rem_out,
  output logic [53:0]        root_out
);
  import cmf_pkg::*;

  localparam int K  = 2 * IDX - 54;
  localparam int KS = (K >= 0) ? K : 0;

  logic        v_r;
  cmf_side_t   side_r;
  logic [53:0] m_r;
  logic [57:0] rem_r;
  logic [57:0] rem_nxt;
  logic [53:0] root_r;
  logic [53:0] root_nxt;
  logic [1:0]  pair;
  logic [57:0] rem_sh;
  logic [57:0] trial;
  logic        ge;

  // below the radicand's lowest pair only zeros are brought down
  assign pair     = (K >= 0) ? 2'(m_in >> KS) : 2'b00;
  assign rem_sh   = {rem_in[55:0], pair};
  assign trial    = {2'b00, root_in, 2'b01};
  assign ge       = rem_sh >= trial;
  assign rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
  assign root_nxt = {root_in[52:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_in;
      m_r    <= m_in;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign v_out    = v_r;
  assign side_out = side_r;
  assign m_out    = m_r;
  assign rem_out  = rem_r;
  assign root_out = root_r;

endmodule
